/* rtl/cos_pkg.sv */
// ----------------------------------------------------------------------------
// cos_pkg
// Shared types and constants for the canonical ordering sorter.
// ----------------------------------------------------------------------------
package cos_pkg;

  localparam int PointW     = 21;
  localparam int ClassW     = 8;
  localparam int CntW       = 7;   // holds 0..64
  localparam int MaxSegment = 64;

  typedef enum logic [0:0] {
    StIdle,
    StDrain
  } state_e;

  // Control broadcast from the controller to every cell
  typedef struct packed {
    logic              ins;    // insert the request item this cycle
    logic              shift;  // drain: every cell takes its right neighbor
    logic [CntW-1:0]   count;  // entries held before this cycle
    logic [ClassW-1:0] cls;    // class of the arriving item
  } cell_ctl_t;

endpackage

/* rtl/cos_in_if.sv */
// ----------------------------------------------------------------------------
// cos_in_if
// Input channel: one decomposed code point with its class per request.
// ----------------------------------------------------------------------------
interface cos_in_if;
  logic                         valid;
  logic                         ready;
  logic [cos_pkg::PointW-1:0]   code_point;
  logic [cos_pkg::ClassW-1:0]   combining_class;
  logic                         segment_end;

  modport source (output valid, code_point, combining_class, segment_end, input ready);
  modport sink   (input valid, code_point, combining_class, segment_end, output ready);
endinterface

/* rtl/cos_out_if.sv */
// ----------------------------------------------------------------------------
// cos_out_if
// Output channel: one code point of the sorted segment per request.
// ----------------------------------------------------------------------------
interface cos_out_if;
  logic                         valid;
  logic                         ready;
  logic [cos_pkg::PointW-1:0]   sorted_code_point;
  logic [cos_pkg::ClassW-1:0]   sorted_class;
  logic                         last_of_run;
  logic                         overflow_seen;

  modport source (output valid, sorted_code_point, sorted_class, last_of_run,
                  overflow_seen, input ready);
  modport sink   (input valid, sorted_code_point, sorted_class, last_of_run,
                  overflow_seen, output ready);
endinterface

/* rtl/cos_cell.sv */
// ----------------------------------------------------------------------------
// cos_cell
// One slot of the sorting chain: holds an entry, shifts right on insert,
// shifts left on drain.
// ----------------------------------------------------------------------------
module cos_cell #(
  parameter int Idx = 0
) (
  input  logic                       clk_i,
  input  cos_pkg::cell_ctl_t         ctl_i,
  input  logic [cos_pkg::PointW-1:0] new_point_i,
  // left neighbor
  input  logic                       left_move_i,
  input  logic [cos_pkg::PointW-1:0] left_point_i,
  input  logic [cos_pkg::ClassW-1:0] left_cls_i,
  input  logic                       left_tail_i,
  // right neighbor
  input  logic [cos_pkg::PointW-1:0] right_point_i,
  input  logic [cos_pkg::ClassW-1:0] right_cls_i,
  input  logic                       right_tail_i,
  // own state
  output logic                       move_o,
  output logic [cos_pkg::PointW-1:0] point_o,
  output logic [cos_pkg::ClassW-1:0] cls_o,
  output logic                       tail_o
);

  localparam logic [cos_pkg::CntW-1:0] IdxC = cos_pkg::CntW'(Idx);

  logic [cos_pkg::PointW-1:0] point_q, point_d;
  logic [cos_pkg::ClassW-1:0] cls_q, cls_d;
  logic                       tail_q, tail_d;   // entry is in the trailing non-starter run
  logic                       occ, at_end, new_ns;

  assign occ    = IdxC < ctl_i.count;
  assign at_end = IdxC == ctl_i.count;
  assign new_ns = ctl_i.cls != '0;

  // Trailing run is sorted, so this is true on a contiguous suffix
  assign move_o = ctl_i.ins && occ && tail_q && new_ns && (cls_q > ctl_i.cls);

  always_comb begin
    point_d = point_q;
    cls_d   = cls_q;
    tail_d  = tail_q;
    if (ctl_i.shift) begin
      point_d = right_point_i;
      cls_d   = right_cls_i;
      tail_d  = right_tail_i;
    end else if (ctl_i.ins) begin
      if (!new_ns) tail_d = 1'b0;   // a starter closes the run
      if (left_move_i) begin
        point_d = left_point_i;
        cls_d   = left_cls_i;
        tail_d  = left_tail_i;
      end else if (move_o || at_end) begin
        point_d = new_point_i;
        cls_d   = ctl_i.cls;
        tail_d  = new_ns;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    point_q <= point_d;
    cls_q   <= cls_d;
    tail_q  <= tail_d;
  end

  assign point_o = point_q;
  assign cls_o   = cls_q;
  assign tail_o  = tail_q;

endmodule

/* rtl/cos_ctrl.sv */
// ----------------------------------------------------------------------------
// cos_ctrl
// Fill count, overflow flag and collect/drain sequencing.
// ----------------------------------------------------------------------------
module cos_ctrl #(
  parameter int MaxSegment = cos_pkg::MaxSegment
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic                       in_end_i,
  input  logic [cos_pkg::ClassW-1:0] in_cls_i,
  output logic                       in_ready_o,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic                       out_last_o,
  output logic                       out_ovf_o,
  output cos_pkg::cell_ctl_t         ctl_o
);

  localparam logic [cos_pkg::CntW-1:0] MaxC = cos_pkg::CntW'(MaxSegment);
  localparam logic [cos_pkg::CntW-1:0] OneC = cos_pkg::CntW'(1);

  cos_pkg::state_e            state_q, state_d;
  logic [cos_pkg::CntW-1:0]   count_q, count_d;
  logic                       ovf_q, ovf_d;
  logic                       in_acc, out_acc, room;

  assign in_ready_o  = state_q == cos_pkg::StIdle;
  assign out_valid_o = state_q == cos_pkg::StDrain;
  assign in_acc      = in_valid_i && in_ready_o;
  assign out_acc     = out_valid_o && out_ready_i;
  assign room        = count_q < MaxC;
  assign out_last_o  = count_q == OneC;
  assign out_ovf_o   = ovf_q;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    ovf_d   = ovf_q;
    unique case (state_q)
      cos_pkg::StIdle: begin
        if (in_acc) begin
          if (room) count_d = count_q + OneC;
          else      ovf_d   = 1'b1;
          if (in_end_i) state_d = cos_pkg::StDrain;
        end
      end
      cos_pkg::StDrain: begin
        if (out_acc) begin
          count_d = count_q - OneC;
          if (out_last_o) begin
            ovf_d   = 1'b0;
            state_d = cos_pkg::StIdle;
          end
        end
      end
      default: state_d = cos_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cos_pkg::StIdle;
      count_q <= '0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
    end
  end

  assign ctl_o.ins   = in_acc && room;
  assign ctl_o.shift = out_acc;
  assign ctl_o.count = count_q;
  assign ctl_o.cls   = in_cls_i;

  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> count_q != '0)
    else $error("drain with empty store");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= MaxC)
    else $error("fill count beyond store depth");

  a_full_drop_sets_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !room) |=> ovf_q)
    else $error("dropped item did not flag overflow");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_last_o) |=> (count_q == '0 && !ovf_q && in_ready_o))
    else $error("store not cleared after last result");

endmodule

/* rtl/canonical_ordering_sorter_top.sv */
// Timing: an item is inserted in the cycle it is accepted; on segment end the
//   first result is valid the next cycle, then one result per cycle while
//   out_req_o.ready is high. Throughput: one item per cycle while collecting;
//   no input request is taken while a segment drains.
// Reset (rst_ni, async, active low) empties the store and clears overflow.
// ----------------------------------------------------------------------------
// canonical_ordering_sorter_top
// Canonical ordering of one decomposed segment by a chain of insertion cells.
// ----------------------------------------------------------------------------
module canonical_ordering_sorter_top #(
  parameter int MAX_SEGMENT = cos_pkg::MaxSegment   // 2..64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  cos_in_if.sink        in_req_i,
  cos_out_if.source     out_req_o
);

  cos_pkg::cell_ctl_t ctl;

  // Per-cell taps of the chain
  logic [cos_pkg::PointW-1:0] point [MAX_SEGMENT];
  logic [cos_pkg::ClassW-1:0] cls   [MAX_SEGMENT];
  logic                       tail  [MAX_SEGMENT];
  logic                       move  [MAX_SEGMENT];

  // Controller: fill count, overflow flag, collect/drain state
  cos_ctrl #(
    .MaxSegment (MAX_SEGMENT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_req_i.valid),
    .in_end_i    (in_req_i.segment_end),
    .in_cls_i    (in_req_i.combining_class),
    .in_ready_o  (in_req_i.ready),
    .out_valid_o (out_req_o.valid),
    .out_ready_i (out_req_o.ready),
    .out_last_o  (out_req_o.last_of_run),
    .out_ovf_o   (out_req_o.overflow_seen),
    .ctl_o       (ctl)
  );

  // Insert: each cell of the trailing run whose class exceeds the new one
  // hands its entry right; the leftmost such cell (or the first free one)
  // takes the new item. Drain: the whole row shifts left toward cell 0.
  for (genvar i = 0; i < MAX_SEGMENT; i++) begin : g_cell
    localparam int Lft = (i == 0) ? 0 : i - 1;
    localparam int Rgt = (i == MAX_SEGMENT - 1) ? i : i + 1;

    cos_cell #(
      .Idx (i)
    ) u_cell (
      .clk_i         (clk_i),
      .ctl_i         (ctl),
      .new_point_i   (in_req_i.code_point),
      .left_move_i   ((i == 0) ? 1'b0 : move[Lft]),
      .left_point_i  (point[Lft]),
      .left_cls_i    (cls[Lft]),
      .left_tail_i   (tail[Lft]),
      .right_point_i (point[Rgt]),
      .right_cls_i   (cls[Rgt]),
      .right_tail_i  (tail[Rgt]),
      .move_o        (move[i]),
      .point_o       (point[i]),
      .cls_o         (cls[i]),
      .tail_o        (tail[i])
    );
  end

  // Head of the row is the result register
  assign out_req_o.sorted_code_point = point[0];
  assign out_req_o.sorted_class      = cls[0];

endmodule
